[sv/hne_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hne_pkg;
  localparam int unsigned GridMaxDefault     = 256;
  localparam int unsigned NormalFracDefault  = 14;
  localparam int unsigned LenExtra           = 10;
  localparam int unsigned CfgGridSizeIdx     = 0;
  localparam logic [8:0]  GridSizeReset      = 9'd256;
  localparam logic [17:0] UpTerm             = 18'sd512;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_L,
    ST_RD_R,
    ST_RD_D,
    ST_RD_U,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SQ,
    M_SUM,
    M_SQRT,
    M_DIV,
    M_DONE
  } math_state_e;

  // Values formed by the sequencer and handed to the math unit.
  typedef struct packed {
    logic               start;
    logic signed [16:0] dx;
    logic signed [16:0] dz;
  } math_req_t;
endpackage
`default_nettype wire

[sv/heightmap_normal_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Heightmap normal engine. Holds a GridMax x GridMax grid of Q8.8 heights in
// one RAM with a registered read and answers normal queries. A write
// transaction (action 0) is accepted and produces no result; the next
// transaction may follow on the next cycle. A query (action 1) reads its
// four clamped neighbours one per cycle from the RAM, then the math unit
// squares the differences, runs a bit-serial square root and three restoring
// divisions. No new transaction is accepted while a query is in progress;
// the next one can be accepted from the cycle in which the result becomes
// valid, and a result that is still held by a stalled receiver delays the
// next result. A query outside the grid skips the reads and the math and
// goes straight to ST_OUT, which returns bad_position. grid_size (byte
// address 0) clamps to 2..GridMax. The RAM has no reset; entries read before
// being written return undefined normals.
module heightmap_normal_engine #(
  parameter int unsigned GridMax    = hne_pkg::GridMaxDefault,
  parameter int unsigned NormalFrac = hne_pkg::NormalFracDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // bits: [7:0] row, [15:8] col, [31:16] height
  input  wire logic [31:0] s_axis_tdata,
  // bits: [0] action
  input  wire logic        s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // bits: [15:0] normal_x, [30:16] normal_y, [46:31] normal_z
  output      logic [47:0] m_axis_tdata,
  // bits: [0] bad_position
  output      logic        m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  localparam int unsigned IW = $clog2(GridMax);
  localparam int unsigned AW = 2 * IW;
  localparam logic [10:0] GMax = 11'(GridMax);

  hne_pkg::state_e st_q, st_d;
  logic [8:0]  gsize_q;
  logic [10:0] n;
  logic [IW-1:0] row_q, col_q;
  logic signed [15:0] hl_q, hr_q, hd_q;
  logic [AW-1:0] raddr;
  logic [15:0] rdata;
  logic        we;
  logic        in_grid;
  logic        bad_q;
  hne_pkg::math_req_t mreq;
  logic        mdone;
  logic [15:0] nx, nz;
  logic [14:0] ny;
  logic [47:0] odata_q;
  logic        ouser_q, ovalid_q;
  logic [IW-1:0] rm, rp, cm, cp, nm1;

  assign pready = 1'b1;
  assign prdata = {23'd0, gsize_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q <= hne_pkg::GridSizeReset;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      gsize_q <= pwdata[8:0];
    end
  end

  assign n = (gsize_q < 9'd2) ? 11'd2 : ((11'(gsize_q) > GMax) ? GMax : 11'(gsize_q));
  assign nm1 = IW'(n - 11'd1);
  assign in_grid = (11'(s_axis_tdata[7:0]) < n) && (11'(s_axis_tdata[15:8]) < n);

  assign rm = (row_q == '0) ? '0 : row_q - 1'b1;
  assign rp = (11'(row_q) + 11'd1 >= n) ? nm1 : row_q + 1'b1;
  assign cm = (col_q == '0) ? '0 : col_q - 1'b1;
  assign cp = (11'(col_q) + 11'd1 >= n) ? nm1 : col_q + 1'b1;

  assign s_axis_tready = (st_q == hne_pkg::ST_IDLE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      hne_pkg::ST_IDLE:
        if (s_axis_tvalid) begin
          if (!s_axis_tuser) st_d = hne_pkg::ST_IDLE;
          else if (!in_grid) st_d = hne_pkg::ST_OUT;
          else st_d = hne_pkg::ST_RD_L;
        end
      hne_pkg::ST_RD_L: st_d = hne_pkg::ST_RD_R;
      hne_pkg::ST_RD_R: st_d = hne_pkg::ST_RD_D;
      hne_pkg::ST_RD_D: st_d = hne_pkg::ST_RD_U;
      hne_pkg::ST_RD_U: st_d = hne_pkg::ST_SQ;
      hne_pkg::ST_SQ:   st_d = hne_pkg::ST_SQRT;
      hne_pkg::ST_SQRT: if (mdone) st_d = hne_pkg::ST_OUT;
      hne_pkg::ST_OUT:  if (!ovalid_q || m_axis_tready) st_d = hne_pkg::ST_IDLE;
      default:          st_d = hne_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (st_q)
      hne_pkg::ST_RD_L: raddr = {rm, col_q};
      hne_pkg::ST_RD_R: raddr = {rp, col_q};
      hne_pkg::ST_RD_D: raddr = {row_q, cm};
      default:          raddr = {row_q, cp};
    endcase
    we = (st_q == hne_pkg::ST_IDLE) && s_axis_tvalid && !s_axis_tuser && in_grid;
    mreq.start = (st_q == hne_pkg::ST_SQ);
    mreq.dx = 17'(hl_q) - 17'(hr_q);
    // In ST_SQ the RAM output holds the upper neighbour.
    mreq.dz = 17'(hd_q) - 17'(signed'(rdata));
  end

  hne_ram #(.Width(16), .Depth(1 << AW)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i ({IW'(s_axis_tdata[7:0]), IW'(s_axis_tdata[15:8])}),
    .wdata_i (s_axis_tdata[31:16]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hne_math #(.NormalFrac(NormalFrac)) u_math (
    .clk_i, .rst_ni, .req_i(mreq), .done_o(mdone), .nx_o(nx), .ny_o(ny), .nz_o(nz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= hne_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == hne_pkg::ST_OUT && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == hne_pkg::ST_IDLE && s_axis_tvalid) begin
      row_q <= IW'(s_axis_tdata[7:0]);
      col_q <= IW'(s_axis_tdata[15:8]);
      bad_q <= !in_grid;
    end
    if (st_q == hne_pkg::ST_RD_R) hl_q <= rdata;
    if (st_q == hne_pkg::ST_RD_D) hr_q <= rdata;
    if (st_q == hne_pkg::ST_RD_U) hd_q <= rdata;
    if (st_q == hne_pkg::ST_OUT && (!ovalid_q || m_axis_tready)) begin
      ouser_q <= bad_q;
      odata_q <= bad_q ? 48'd0 : {1'b0, nz, ny, nx};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
endmodule
`default_nettype wire

[sv/hne_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module hne_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/hne_math.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial square root of (dx^2 + 512^2 + dz^2) << 20, then three
// restoring divisions done one quotient bit per cycle.
module hne_math #(
  parameter int unsigned NormalFrac = hne_pkg::NormalFracDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hne_pkg::math_req_t req_i,
  output      logic              done_o,
  output      logic [15:0]       nx_o,
  output      logic [14:0]       ny_o,
  output      logic [15:0]       nz_o
);
  localparam int unsigned SW = 56;           // radicand width
  localparam int unsigned LW = 28;           // root width
  localparam int unsigned QW = NormalFrac + 2;
  localparam int unsigned Sh = NormalFrac + hne_pkg::LenExtra;
  localparam int unsigned NW = 16 + Sh + 2;  // numerator width
  localparam logic [QW-1:0] One = QW'(1) << NormalFrac;

  hne_pkg::math_state_e st_q, st_d;
  logic [33:0]      sqx_q, sqz_q;
  logic [SW-1:0]    rad_q, rem_q;
  logic [LW-1:0]    root_q;
  logic [5:0]       cnt_q;
  logic [1:0]       comp_q;
  logic [NW-1:0]    num_q, drem_q;
  logic [QW-1:0]    quo_q;
  logic [16:0]      magx_q, magz_q;
  logic             negx_q, negz_q;
  logic [15:0]      nx_q, nz_q;
  logic [14:0]      ny_q;

  logic [SW+1:0]    trial;
  logic [SW+1:0]    rem_sh;
  logic [LW-1:0]    root_fin;
  logic [NW:0]      drem_sh;
  logic             qbit;
  logic [QW-1:0]    qnext, qfin;
  logic [16:0]      mag_sel;
  logic [NW-1:0]    num_init;

  always_comb begin
    rem_sh   = {rem_q, rad_q[SW-1 -: 2]};
    trial    = {root_q, 2'b01};
    root_fin = {root_q[LW-2:0], (rem_sh >= trial)};
    drem_sh  = {drem_q, num_q[NW-1]};
    qbit     = (drem_sh >= (NW+1)'(root_q));
    qnext    = {quo_q[QW-2:0], qbit};
    qfin     = (qnext > One) ? One : qnext;
    // Numerator of the component that follows the current one, with half
    // of the root added so that the quotient rounds half up.
    case (comp_q)
      2'd0:    mag_sel = 17'd512;
      default: mag_sel = magz_q;
    endcase
    num_init = (NW'(mag_sel) << Sh) + NW'(root_q >> 1);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      hne_pkg::M_IDLE: if (req_i.start) st_d = hne_pkg::M_SQ;
      hne_pkg::M_SQ:   st_d = hne_pkg::M_SUM;
      hne_pkg::M_SUM:  st_d = hne_pkg::M_SQRT;
      hne_pkg::M_SQRT: if (cnt_q == 6'd0) st_d = hne_pkg::M_DIV;
      hne_pkg::M_DIV:  if (cnt_q == 6'd0 && comp_q == 2'd2) st_d = hne_pkg::M_DONE;
      hne_pkg::M_DONE: st_d = hne_pkg::M_IDLE;
      default:         st_d = hne_pkg::M_IDLE;
    endcase
  end

  always_comb begin
    done_o = (st_q == hne_pkg::M_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hne_pkg::M_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      hne_pkg::M_IDLE: begin
        negx_q <= req_i.dx[16];
        negz_q <= req_i.dz[16];
        magx_q <= req_i.dx[16] ? 17'(-req_i.dx) : 17'(req_i.dx);
        magz_q <= req_i.dz[16] ? 17'(-req_i.dz) : 17'(req_i.dz);
      end
      hne_pkg::M_SQ: begin
        sqx_q <= 34'(magx_q * magx_q);
        sqz_q <= 34'(magz_q * magz_q);
      end
      hne_pkg::M_SUM: begin
        rad_q  <= SW'({2'b0, sqx_q} + {2'b0, sqz_q} + 36'd262144) << 20;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= 6'(LW - 1);
      end
      hne_pkg::M_SQRT: begin
        rad_q  <= rad_q << 2;
        root_q <= root_fin;
        if (rem_sh >= trial) begin
          rem_q <= SW'(rem_sh - trial);
        end else begin
          rem_q <= SW'(rem_sh);
        end
        if (cnt_q == 6'd0) begin
          comp_q <= 2'd0;
          cnt_q  <= 6'(NW - 1);
          drem_q <= '0;
          quo_q  <= '0;
          num_q  <= (NW'(magx_q) << Sh) + NW'(root_fin >> 1);
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
      hne_pkg::M_DIV: begin
        if (cnt_q == 6'd0) begin
          case (comp_q)
            2'd0:    nx_q <= negx_q ? 16'(-17'(qfin)) : 16'(qfin);
            2'd1:    ny_q <= 15'(qfin);
            default: nz_q <= negz_q ? 16'(-17'(qfin)) : 16'(qfin);
          endcase
          comp_q <= comp_q + 2'd1;
          cnt_q  <= 6'(NW - 1);
          drem_q <= '0;
          quo_q  <= '0;
          num_q  <= num_init;
        end else begin
          num_q <= num_q << 1;
          quo_q <= qnext;
          if (qbit) begin
            drem_q <= NW'(drem_sh - (NW+1)'(root_q));
          end else begin
            drem_q <= NW'(drem_sh);
          end
          cnt_q <= cnt_q - 6'd1;
        end
      end
      default: ;
    endcase
  end

  assign nx_o = nx_q;
  assign ny_o = ny_q;
  assign nz_o = nz_q;
endmodule
`default_nettype wire

[sv/hne_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module hne_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("bad position with nonzero normal");
  a_up_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[30:16] != 15'd0)
    else $error("up component is zero");
endmodule
bind heightmap_normal_engine hne_checker u_chk (
  .clk_i, .rst_ni,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

[bench/heightmap_normal_engine_tb.sv]
`timescale 1ns / 1ps
module heightmap_normal_engine_tb;
  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;
  localparam int unsigned GridN = hne_pkg::GridMaxDefault;
  localparam int unsigned Frac = hne_pkg::NormalFracDefault;
  localparam int unsigned LenExtra = hne_pkg::LenExtra;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned ItemsTarget = 1550;

  typedef struct packed {
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic        bad;
  } normal_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // bits: [7:0] row, [15:8] col, [31:16] height
  logic [31:0] s_axis_tdata = '0;
  // bits: [0] action
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // bits: [15:0] normal_x, [30:16] normal_y, [46:31] normal_z
  logic [47:0] m_axis_tdata;
  // bits: [0] bad_position
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  heightmap_normal_engine DUT (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the block's state.
  logic [15:0] height_mem [GridN*GridN];
  bit          height_known [GridN*GridN];
  logic [8:0]  grid_reg = hne_pkg::GridSizeReset;
  normal_t     pending_normals[$];
  int          items_sent = 0;
  int          mismatches = 0;
  bit          idling_on = 1'b1;

  function automatic int unsigned size_in_use();
    if (grid_reg < 2) return 2;
    if (grid_reg > GridN) return GridN;
    return grid_reg;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint scale_to_unit(longint c, longint unsigned len);
    longint unsigned mag, q;
    mag = (c < 0) ? -c : c;
    q = ((mag << (Frac + LenExtra)) + (len >> 1)) / len;
    if (q > (64'd1 << Frac)) q = 64'd1 << Frac;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sample(int unsigned r, int unsigned c);
    return longint'($signed(height_mem[r*GridN + c]));
  endfunction

  function automatic normal_t surface_normal(int unsigned r, int unsigned c);
    normal_t res;
    int unsigned n, rl, rr, cd, cu;
    longint dx, dz, ux, uy, uz;
    longint unsigned sum, len;
    n = size_in_use();
    res = '0;
    if (r >= n || c >= n) begin
      res.bad = 1'b1;
      return res;
    end
    rl = (r == 0) ? 0 : r - 1;
    rr = (r + 1 >= n) ? n - 1 : r + 1;
    cd = (c == 0) ? 0 : c - 1;
    cu = (c + 1 >= n) ? n - 1 : c + 1;
    dx = sample(rl, c) - sample(rr, c);
    dz = sample(r, cd) - sample(r, cu);
    sum = dx*dx + 512*512 + dz*dz;
    len = isqrt(sum << (2*LenExtra));
    ux = scale_to_unit(dx, len);
    uy = scale_to_unit(512, len);
    uz = scale_to_unit(dz, len);
    res.nx = ux[15:0];
    res.ny = uy[14:0];
    res.nz = uz[15:0];
    return res;
  endfunction

  task automatic send_item(logic act, logic [7:0] r, logic [7:0] c, logic [15:0] h);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {h, c, r};
    s_axis_tuser <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (act == ActQuery) begin
      pending_normals.push_back(surface_normal(r, c));
    end else if (r < size_in_use() && c < size_in_use()) begin
      height_mem[r*GridN + c] = h;
      height_known[r*GridN + c] = 1'b1;
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_grid_size(logic [8:0] val);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 1'(hne_pkg::CfgGridSizeIdx * 4);
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    grid_reg = val;
  endtask

  // Writes any neighbour not yet known, and at random some known ones, then queries the point.
  task automatic query_prepared(int unsigned r, int unsigned c);
    int unsigned n;
    int unsigned nr[4], nc[4];
    n = size_in_use();
    nr = '{(r == 0) ? 0 : r - 1, (r + 1 >= n) ? n - 1 : r + 1, r, r};
    nc = '{c, c, (c == 0) ? 0 : c - 1, (c + 1 >= n) ? n - 1 : c + 1};
    for (int k = 0; k < 4; k++) begin
      if (!height_known[nr[k]*GridN + nc[k]] || $urandom_range(0, 2) == 0)
        send_item(ActWrite, 8'(nr[k]), 8'(nc[k]), 16'($urandom));
    end
    send_item(ActQuery, 8'(r), 8'(c), 16'($urandom));
  endtask

  // Writes all four neighbours with given heights, then queries.
  task automatic query_shaped(int unsigned r, int unsigned c,
                              logic [15:0] hl, logic [15:0] hr,
                              logic [15:0] hd, logic [15:0] hu);
    int unsigned n;
    n = size_in_use();
    send_item(ActWrite, 8'((r == 0) ? 0 : r - 1), 8'(c), hl);
    send_item(ActWrite, 8'((r + 1 >= n) ? n - 1 : r + 1), 8'(c), hr);
    send_item(ActWrite, 8'(r), 8'((c == 0) ? 0 : c - 1), hd);
    send_item(ActWrite, 8'(r), 8'((c + 1 >= n) ? n - 1 : c + 1), hu);
    send_item(ActQuery, 8'(r), 8'(c), 16'h0000);
  endtask

  task automatic test_full_grid_extremes();
    query_shaped(0, 0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    query_shaped(255, 255, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    query_shaped(128, 77, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    query_prepared(0, 255);
  endtask

  task automatic test_small_grids();
    set_grid_size(9'd0);
    query_shaped(1, 1, 16'h0100, 16'hFF00, 16'h0001, 16'hFFFF);
    send_item(ActQuery, 2, 0, 16'h0);
    send_item(ActWrite, 200, 9, 16'h1234);
    set_grid_size(9'd511);
    query_prepared(255, 0);
    set_grid_size(9'd3);
    query_shaped(1, 2, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
    send_item(ActQuery, 0, 3, 16'h0);
    set_grid_size(9'd1);
    send_item(ActQuery, 1, 1, 16'h0);
  endtask

  task automatic test_random_traffic();
    logic [8:0] sizes[] = '{9'd256, 9'd2, 9'd17, 9'd5, 9'd300, 9'd255, 9'd9, 9'd0};
    int unsigned phase, n, pick;
    phase = 0;
    while (items_sent < ItemsTarget) begin
      if (items_sent > (phase + 1) * 170 && phase < 8) begin
        set_grid_size(phase < sizes.size() ? sizes[phase] : 9'($urandom_range(2, 40)));
        phase++;
      end
      if (items_sent > ItemsTarget - 300) idling_on = 1'b0;
      n = size_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        query_prepared($urandom_range(0, n - 1), $urandom_range(0, n - 1));
      end else if (pick < 85) begin
        send_item(ActWrite, 8'($urandom), 8'($urandom), 16'($urandom));
      end else if (pick < 97) begin
        if (n < GridN) begin
          send_item(ActQuery, 8'($urandom_range(n, 255)), 8'($urandom), 16'($urandom));
        end else begin
          query_prepared(8'($urandom), 8'($urandom));
        end
      end else begin
        wait_drained();
      end
    end
    stop_sending();
  endtask

  // Result receiver with random stall bursts.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    normal_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[30:16], m_axis_tdata[46:31], m_axis_tuser};
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", got);
      end else begin
        want = pending_normals.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h z=%h bad=%b, got x=%h y=%h z=%h bad=%b",
                     want.nx, want.ny, want.nz, want.bad, got.nx, got.ny, got.nz, got.bad);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_grid_extremes();
    test_small_grids();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
